>>> sv/ansi_text_terminal_engine_core_assert.svh
// Assertion macros shared by the terminal engine RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ANSI_TEXT_TERMINAL_ENGINE_CORE_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ttx_pkg.sv
// Types and constant codes of the ANSI text terminal engine.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
`default_nettype none
package ttx_pkg;

  // One character cell, packed as the store keeps it.
  typedef struct packed {
    logic [3:0] bg;
    logic [3:0] fg;
    logic [7:0] ch;
  } cell_t;

  // Commands carried in the input tuser.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Result events carried in the output tuser.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_WRITE = 2'd1;
  localparam logic [1:0] EV_READ  = 2'd2;
  localparam logic [1:0] EV_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_DEF_FG  = 2'd2;
  localparam logic [1:0] REG_DEF_BG  = 2'd3;

  // Escape parser modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam int unsigned TAB_STEP = 4;
  localparam logic [15:0] PARAM_MAX = 16'hFFFF;

  // Store contents after reset: space, light gray on black.
  localparam cell_t CELL_RESET = '{bg: 4'd0, fg: 4'd7, ch: CH_SPACE};

endpackage
`default_nettype wire

>>> sv/ttx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ttx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/ansi_text_terminal_engine_core.sv
// Top level of the ANSI text terminal engine: parser, cursor and sequencer.
// Depends on ttx_pkg, ttx_ram and ansi_text_terminal_engine_core_assert.svh.
//
// The engine takes one command per input transfer and returns exactly one
// result transfer for it. After reset it writes a blank cell to each of the
// MAX_COLS*MAX_ROWS store cells and accepts no input meanwhile; configuration
// writes are taken at any time. One sequencer drives the store's single write
// and single read port, so the time per item is set by store traffic: an SGR
// sequence applies its parameters one at a time, a cell read waits for the
// registered read data, a clear writes every cell of the area, and a scroll
// moves each cell up a line with one read and one write, then blanks the
// bottom line. The next item is accepted while a finished result still waits
// in the output register.
`timescale 1ns / 1ps
`default_nettype none
module ansi_text_terminal_engine_core #(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_PARAMS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // char_code[7:0], clear_fg[11:8], clear_bg[15:12], read_col[22:16],
  // read_row[28:23], zero pad
  input  wire logic [31:0] in_tdata,
  // command[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cell_col[6:0], cell_row[12:7], cell_char[20:13], cell_fg[24:21],
  // cell_bg[28:25], scrolled[29], cursor_col[36:30], cursor_row[42:37],
  // palette_write[43], palette_index[47:44], palette_rgb[71:48]
  output logic [71:0]      out_tdata,
  // event_res[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TAB_STEP_I = ttx_pkg::TAB_STEP;
  localparam int CW    = $clog2(MAX_COLS + TAB_STEP_I);
  localparam int RW    = $clog2(MAX_ROWS + 2);
  localparam int PIW   = $clog2(MAX_PARAMS);

  // Sequencer states.
  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_EXEC   = 4'd2;
  localparam logic [3:0] ST_SGR    = 4'd3;
  localparam logic [3:0] ST_POST   = 4'd4;
  localparam logic [3:0] ST_SCR_RD = 4'd5;
  localparam logic [3:0] ST_SCR_WR = 4'd6;
  localparam logic [3:0] ST_FILL   = 4'd7;
  localparam logic [3:0] ST_CLEAR  = 4'd8;
  localparam logic [3:0] ST_RDWAIT = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] init_r, init_nxt;

  // Configuration registers.
  logic [7:0] columns_r;
  logic [6:0] rows_r;
  logic [3:0] dfg_r, dbg_r;

  // Terminal state.
  logic [CW-1:0]  ccol_r, ccol_nxt;
  logic [RW-1:0]  cline_r, cline_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [15:0]    pv_r [MAX_PARAMS];
  logic [15:0]    pv_nxt [MAX_PARAMS];
  logic [PIW-1:0] pidx_r, pidx_nxt;
  logic [PIW-1:0] sgri_r, sgri_nxt;
  logic [3:0]     curfg_r, curfg_nxt, curbg_r, curbg_nxt;

  // Latched input item.
  logic [1:0] cmd_r, cmd_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic [3:0] clfg_r, clfg_nxt, clbg_r, clbg_nxt;
  logic [6:0] rcol_r, rcol_nxt;
  logic [5:0] rrow_r, rrow_nxt;

  // Sweep counters for clear and scroll.
  logic [RW-1:0] swr_r, swr_nxt;
  logic [CW-1:0] swc_r, swc_nxt;

  // Result being built.
  logic [1:0]  rev_r, rev_nxt;
  logic [6:0]  rcc_r, rcc_nxt;
  logic [5:0]  rcr_r, rcr_nxt;
  ttx_pkg::cell_t rcell_r, rcell_nxt;
  logic        rscr_r, rscr_nxt;
  logic        rpw_r, rpw_nxt;
  logic [3:0]  rpi_r, rpi_nxt;
  logic [23:0] rrgb_r, rrgb_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  logic [71:0] out_data_r, out_data_nxt;

  // Store ports.
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  ttx_pkg::cell_t ram_wdata;
  logic [15:0]    ram_rdata;
  ttx_pkg::cell_t rd_cell;

  // Helpers.
  logic [CW-1:0]  nc;
  logic [RW-1:0]  nr;
  logic [PIW-1:0] psel;
  logic [15:0]    psv;
  logic [19:0]    dsum;
  logic [CW-1:0]  pc;
  logic [RW-1:0]  pl;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  // Effective area: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (columns_r == 8'd0) begin
      nc = CW'(1);
    end else if (32'(columns_r) > 32'(MAX_COLS)) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(columns_r);
    end
    if (rows_r == 7'd0) begin
      nr = RW'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(rows_r);
    end
  end

  // Single parameter read mux shared by the digit and SGR paths.
  assign psel = (state_r == ST_SGR) ? sgri_r : pidx_r;
  assign psv  = pv_r[psel];
  assign dsum = ({4'd0, psv} << 3) + ({4'd0, psv} << 1) + 20'(ch_r - ttx_pkg::CH_0);
  assign rd_cell = ttx_pkg::cell_t'(ram_rdata);

  // Wrap check on the cursor as it stands after the command.
  always_comb begin
    pc = ccol_r;
    pl = cline_r;
    if (ccol_r >= nc) begin
      pc = '0;
      pl = cline_r + RW'(1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    ccol_nxt  = ccol_r;
    cline_nxt = cline_r;
    mode_nxt  = mode_r;
    pv_nxt    = pv_r;
    pidx_nxt  = pidx_r;
    sgri_nxt  = sgri_r;
    curfg_nxt = curfg_r;
    curbg_nxt = curbg_r;
    cmd_nxt   = cmd_r;
    ch_nxt    = ch_r;
    clfg_nxt  = clfg_r;
    clbg_nxt  = clbg_r;
    rcol_nxt  = rcol_r;
    rrow_nxt  = rrow_r;
    swr_nxt   = swr_r;
    swc_nxt   = swc_r;
    rev_nxt   = rev_r;
    rcc_nxt   = rcc_r;
    rcr_nxt   = rcr_r;
    rcell_nxt = rcell_r;
    rscr_nxt  = rscr_r;
    rpw_nxt   = rpw_r;
    rpi_nxt   = rpi_r;
    rrgb_nxt  = rrgb_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    case (state_r)
      // Blank the whole store after reset.
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_r;
        ram_wdata = ttx_pkg::CELL_RESET;
        if (init_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          init_nxt = init_r + AW'(1);
        end
      end

      // Take an item and clear the result under construction.
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          ch_nxt    = in_tdata[7:0];
          clfg_nxt  = in_tdata[11:8];
          clbg_nxt  = in_tdata[15:12];
          rcol_nxt  = in_tdata[22:16];
          rrow_nxt  = in_tdata[28:23];
          rev_nxt   = ttx_pkg::EV_NONE;
          rcc_nxt   = '0;
          rcr_nxt   = '0;
          rcell_nxt = '0;
          rscr_nxt  = 1'b0;
          rpw_nxt   = 1'b0;
          rpi_nxt   = '0;
          rrgb_nxt  = '0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_r)
          ttx_pkg::CMD_PUT: begin
            state_nxt = ST_POST;
            if (ch_r == ttx_pkg::CH_LF) begin
              cline_nxt = cline_r + RW'(1);
            end else if (ch_r == ttx_pkg::CH_CR) begin
              ccol_nxt = '0;
            end else if (ch_r == ttx_pkg::CH_TAB) begin
              ccol_nxt = ccol_r + CW'(ttx_pkg::TAB_STEP);
            end else if (ch_r == ttx_pkg::CH_BS) begin
              if (ccol_r != '0) begin
                ccol_nxt = ccol_r - CW'(1);
              end
            end else if (ch_r == ttx_pkg::CH_ESC) begin
              mode_nxt = ttx_pkg::MODE_ESC;
            end else if (ch_r == ttx_pkg::CH_LBRK && mode_r == ttx_pkg::MODE_ESC) begin
              mode_nxt = ttx_pkg::MODE_CSI;
            end else if ((ch_r inside {[ttx_pkg::CH_0:ttx_pkg::CH_9]}) &&
                         mode_r == ttx_pkg::MODE_CSI) begin
              // Accumulate a decimal digit, saturating at the top value.
              pv_nxt[pidx_r] = (dsum > 20'(ttx_pkg::PARAM_MAX)) ? ttx_pkg::PARAM_MAX
                                                                : dsum[15:0];
            end else if (ch_r == ttx_pkg::CH_SEMI && mode_r == ttx_pkg::MODE_CSI) begin
              if (pidx_r < PIW'(MAX_PARAMS - 1)) begin
                pidx_nxt = pidx_r + PIW'(1);
              end
            end else if (ch_r == ttx_pkg::CH_M && mode_r == ttx_pkg::MODE_CSI) begin
              sgri_nxt  = '0;
              state_nxt = ST_SGR;
            end else if (ch_r == ttx_pkg::CH_P && mode_r == ttx_pkg::MODE_CSI) begin
              // Palette write needs four parameters and a valid entry.
              if (pidx_r >= PIW'(3) && pv_r[0] <= 16'd15) begin
                rpw_nxt  = 1'b1;
                rpi_nxt  = pv_r[0][3:0];
                rrgb_nxt = {pv_r[1][7:0], pv_r[2][7:0], pv_r[3][7:0]};
                for (int i = 0; i < MAX_PARAMS; i++) begin
                  pv_nxt[i] = '0;
                end
                pidx_nxt = '0;
                mode_nxt = ttx_pkg::MODE_NORMAL;
              end
            end else begin
              // Printable byte: written only while the cursor is in the area.
              mode_nxt = ttx_pkg::MODE_NORMAL;
              if (ccol_r < nc && cline_r < nr) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(cline_r, ccol_r);
                ram_wdata = '{bg: curbg_r, fg: curfg_r, ch: ch_r};
                rev_nxt   = ttx_pkg::EV_WRITE;
                rcc_nxt   = 7'(ccol_r);
                rcr_nxt   = 6'(cline_r);
                rcell_nxt = '{bg: curbg_r, fg: curfg_r, ch: ch_r};
                ccol_nxt  = ccol_r + CW'(1);
              end
            end
          end
          ttx_pkg::CMD_CLEAR: begin
            curfg_nxt = clfg_r;
            curbg_nxt = clbg_r;
            ccol_nxt  = '0;
            cline_nxt = '0;
            swr_nxt   = '0;
            swc_nxt   = '0;
            rev_nxt   = ttx_pkg::EV_CLEAR;
            state_nxt = ST_CLEAR;
          end
          ttx_pkg::CMD_READ: begin
            rev_nxt = ttx_pkg::EV_READ;
            rcc_nxt = rcol_r;
            rcr_nxt = rrow_r;
            if (32'(rcol_r) < 32'(nc) && 32'(rrow_r) < 32'(nr)) begin
              ram_raddr = cell_addr(RW'(rrow_r), CW'(rcol_r));
              state_nxt = ST_RDWAIT;
            end else begin
              rcell_nxt = '{bg: 4'd0, fg: 4'd0, ch: ttx_pkg::CH_SPACE};
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Apply one SGR parameter per cycle.
      ST_SGR: begin
        if (psv >= 16'd30 && psv <= 16'd37) begin
          curfg_nxt = 4'(psv - 16'd30);
        end else if (psv >= 16'd40 && psv <= 16'd47) begin
          curbg_nxt = 4'(psv - 16'd40);
        end else if (psv >= 16'd90 && psv <= 16'd97) begin
          curfg_nxt = 4'(psv - 16'd90 + 16'd8);
        end else if (psv >= 16'd100 && psv <= 16'd107) begin
          curbg_nxt = 4'(psv - 16'd100 + 16'd8);
        end else if (psv == 16'd1) begin
          if (curfg_r < 4'd8) begin
            curfg_nxt = curfg_r + 4'd8;
          end
        end else if (psv == 16'd0) begin
          curfg_nxt = dfg_r;
          curbg_nxt = dbg_r;
        end
        if (sgri_r == pidx_r) begin
          for (int i = 0; i < MAX_PARAMS; i++) begin
            pv_nxt[i] = '0;
          end
          pidx_nxt  = '0;
          mode_nxt  = ttx_pkg::MODE_NORMAL;
          state_nxt = ST_POST;
        end else begin
          sgri_nxt = sgri_r + PIW'(1);
        end
      end

      // Wrap, then scroll when the cursor ran off the bottom.
      ST_POST: begin
        ccol_nxt  = pc;
        cline_nxt = pl;
        if (pl >= nr) begin
          ccol_nxt  = '0;
          cline_nxt = nr - RW'(1);
          rscr_nxt  = 1'b1;
          swr_nxt   = '0;
          swc_nxt   = '0;
          state_nxt = (nr == RW'(1)) ? ST_FILL : ST_SCR_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_SCR_RD: begin
        ram_raddr = cell_addr(swr_r + RW'(1), swc_r);
        state_nxt = ST_SCR_WR;
      end

      // Move one cell up a line.
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(swr_r, swc_r);
        ram_wdata = rd_cell;
        state_nxt = ST_SCR_RD;
        if (swc_r == nc - CW'(1)) begin
          swc_nxt = '0;
          if (swr_r + RW'(1) == nr - RW'(1)) begin
            state_nxt = ST_FILL;
          end else begin
            swr_nxt = swr_r + RW'(1);
          end
        end else begin
          swc_nxt = swc_r + CW'(1);
        end
      end

      // Blank the new bottom line in the current colors.
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(nr - RW'(1), swc_r);
        ram_wdata = '{bg: curbg_r, fg: curfg_r, ch: ttx_pkg::CH_SPACE};
        if (swc_r == nc - CW'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          swc_nxt = swc_r + CW'(1);
        end
      end

      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(swr_r, swc_r);
        ram_wdata = '{bg: clbg_r, fg: clfg_r, ch: ttx_pkg::CH_SPACE};
        if (swc_r == nc - CW'(1)) begin
          swc_nxt = '0;
          if (swr_r == nr - RW'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            swr_nxt = swr_r + RW'(1);
          end
        end else begin
          swc_nxt = swc_r + CW'(1);
        end
      end

      ST_RDWAIT: begin
        rcell_nxt = rd_cell;
        state_nxt = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = rev_r;
          out_data_nxt  = {rrgb_r, rpi_r, rpw_r, 6'(cline_r), 7'(ccol_r), rscr_r,
                           rcell_r.bg, rcell_r.fg, rcell_r.ch, rcr_r, rcc_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and terminal state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_r      <= '0;
      columns_r   <= 8'd80;
      rows_r      <= 7'd25;
      dfg_r       <= 4'd7;
      dbg_r       <= 4'd0;
      ccol_r      <= '0;
      cline_r     <= '0;
      mode_r      <= ttx_pkg::MODE_NORMAL;
      pidx_r      <= '0;
      sgri_r      <= '0;
      curfg_r     <= 4'd7;
      curbg_r     <= 4'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        pv_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      ccol_r      <= ccol_nxt;
      cline_r     <= cline_nxt;
      mode_r      <= mode_nxt;
      pidx_r      <= pidx_nxt;
      sgri_r      <= sgri_nxt;
      curfg_r     <= curfg_nxt;
      curbg_r     <= curbg_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ttx_pkg::REG_COLUMNS: columns_r <= cfg_data;
          ttx_pkg::REG_ROWS:    rows_r    <= cfg_data[6:0];
          ttx_pkg::REG_DEF_FG:  dfg_r     <= cfg_data[3:0];
          ttx_pkg::REG_DEF_BG:  dbg_r     <= cfg_data[3:0];
          default:              columns_r <= columns_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ch_r       <= ch_nxt;
    clfg_r     <= clfg_nxt;
    clbg_r     <= clbg_nxt;
    rcol_r     <= rcol_nxt;
    rrow_r     <= rrow_nxt;
    swr_r      <= swr_nxt;
    swc_r      <= swc_nxt;
    rev_r      <= rev_nxt;
    rcc_r      <= rcc_nxt;
    rcr_r      <= rcr_nxt;
    rcell_r    <= rcell_nxt;
    rscr_r     <= rscr_nxt;
    rpw_r      <= rpw_nxt;
    rpi_r      <= rpi_nxt;
    rrgb_r     <= rrgb_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  ttx_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // Checks on the sequencer and on the result it builds.
  `include "ansi_text_terminal_engine_core_assert.svh"

  `TTX_ASSERT_NOW(a_init_no_result, state_r == ST_INIT, !out_valid_r, "result during store init")
  `TTX_ASSERT_NOW(a_idle_no_write, state_r == ST_IDLE, !ram_we, "store write while idle")
  `TTX_ASSERT_NOW(a_put_cursor_in_area, state_r == ST_DONE && cmd_r == ttx_pkg::CMD_PUT,
                  ccol_r < nc && cline_r < nr, "cursor outside area after character")
  `TTX_ASSERT_NOW(a_scroll_col_zero, out_valid_r && out_tdata[29], out_tdata[36:30] == 7'd0,
                  "scroll result with nonzero cursor column")

endmodule
`default_nettype wire

>>> dv/tb_ansi_text_terminal_engine_core.sv
// Self-checking testbench for the ANSI text terminal engine top level.
// Depends on ttx_pkg and ansi_text_terminal_engine_core; predicts every result in SystemVerilog.
`timescale 1ns / 1ps
module tb_ansi_text_terminal_engine_core;

  localparam int COLS_MAX  = 128;
  localparam int ROWS_MAX  = 64;
  localparam int SLOTS     = 4;
  localparam int IDLE_GAP  = 64;
  localparam int HOLD_LEN  = 500;
  localparam int DOG_LIMIT = 60000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] data;
  } command_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [6:0]  col;
    logic [5:0]  row;
    logic [7:0]  ch;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic        scrolled;
    logic [6:0]  ccol;
    logic [5:0]  crow;
    logic        pw;
    logic [3:0]  pidx;
    logic [23:0] rgb;
  } terminal_result_t;

  logic        clk;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  ansi_text_terminal_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the terminal state.
  ttx_pkg::cell_t screen [COLS_MAX*ROWS_MAX];
  int unsigned cur_x, cur_y, mode, pidx;
  int unsigned params [SLOTS];
  int unsigned cur_fg, cur_bg;
  int unsigned reg_cols, reg_rows, reg_dfg, reg_dbg;

  command_t         command_feed [$];
  terminal_result_t expected_results [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned hold_asked, hold_done, hold_left;
  int unsigned errors, items_in, results_out, writes_seen, scrolls_seen, palettes_seen;
  int unsigned dog;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned area_w();
    return (reg_cols < 1) ? 1 : (reg_cols > COLS_MAX) ? COLS_MAX : reg_cols;
  endfunction

  function automatic int unsigned area_h();
    return (reg_rows < 1) ? 1 : (reg_rows > ROWS_MAX) ? ROWS_MAX : reg_rows;
  endfunction

  function automatic void reset_params();
    for (int i = 0; i < SLOTS; i++) params[i] = 0;
    pidx = 0;
    mode = ttx_pkg::MODE_NORMAL;
  endfunction

  // Apply one terminal command to the shadow state and queue its result.
  function automatic void terminal_step(input logic [1:0] cmd, input logic [31:0] d);
    terminal_result_t r;
    int unsigned nc, nr, ch, k, v, p;
    ttx_pkg::cell_t c;
    nc = area_w();
    nr = area_h();
    r = '0;
    ch = d[7:0];
    if (cmd == ttx_pkg::CMD_PUT) begin
      if (ch == ttx_pkg::CH_LF) cur_y++;
      else if (ch == ttx_pkg::CH_CR) cur_x = 0;
      else if (ch == ttx_pkg::CH_TAB) cur_x += ttx_pkg::TAB_STEP;
      else if (ch == ttx_pkg::CH_BS) begin
        if (cur_x > 0) cur_x--;
      end else if (ch == ttx_pkg::CH_ESC) mode = ttx_pkg::MODE_ESC;
      else if (ch == ttx_pkg::CH_LBRK && mode == ttx_pkg::MODE_ESC) mode = ttx_pkg::MODE_CSI;
      else if (ch >= ttx_pkg::CH_0 && ch <= ttx_pkg::CH_9 && mode == ttx_pkg::MODE_CSI) begin
        k = (pidx < SLOTS) ? pidx : SLOTS - 1;
        v = params[k] * 10 + (ch - ttx_pkg::CH_0);
        params[k] = (v > ttx_pkg::PARAM_MAX) ? ttx_pkg::PARAM_MAX : v;
      end else if (ch == ttx_pkg::CH_SEMI && mode == ttx_pkg::MODE_CSI) begin
        if (pidx < SLOTS - 1) pidx++;
      end else if (ch == ttx_pkg::CH_M && mode == ttx_pkg::MODE_CSI) begin
        for (int i = 0; i <= pidx && i < SLOTS; i++) begin
          p = params[i];
          if (p >= 30 && p <= 37) cur_fg = p - 30;
          else if (p >= 40 && p <= 47) cur_bg = p - 40;
          else if (p >= 90 && p <= 97) cur_fg = p - 90 + 8;
          else if (p >= 100 && p <= 107) cur_bg = p - 100 + 8;
          else if (p == 1) begin
            if (cur_fg < 8) cur_fg += 8;
          end else if (p == 0) begin
            cur_fg = reg_dfg;
            cur_bg = reg_dbg;
          end
        end
        reset_params();
      end else if (ch == ttx_pkg::CH_P && mode == ttx_pkg::MODE_CSI) begin
        // Palette write needs four parameters and an index within range.
        if (pidx >= 3 && params[0] <= 15) begin
          r.pw = 1'b1;
          r.pidx = params[0][3:0];
          r.rgb = {params[1][7:0], params[2][7:0], params[3][7:0]};
          reset_params();
        end
      end else begin
        mode = ttx_pkg::MODE_NORMAL;
        if (cur_x < nc && cur_y < nr) begin
          c.ch = ch[7:0];
          c.fg = cur_fg[3:0];
          c.bg = cur_bg[3:0];
          screen[cur_y*COLS_MAX + cur_x] = c;
          r.ev = ttx_pkg::EV_WRITE;
          r.col = cur_x[6:0];
          r.row = cur_y[5:0];
          r.ch = ch[7:0];
          r.fg = cur_fg[3:0];
          r.bg = cur_bg[3:0];
          cur_x++;
        end
      end
      // Wrap to the next line, then scroll if past the bottom.
      if (cur_x >= nc) begin
        cur_y++;
        cur_x = 0;
      end
      if (cur_y >= nr) begin
        for (int y = 0; y + 1 < nr; y++)
          for (int x = 0; x < nc; x++) screen[y*COLS_MAX + x] = screen[(y+1)*COLS_MAX + x];
        for (int x = 0; x < nc; x++)
          screen[(nr-1)*COLS_MAX + x] = '{bg: cur_bg[3:0], fg: cur_fg[3:0],
                                          ch: ttx_pkg::CH_SPACE};
        cur_y = nr - 1;
        cur_x = 0;
        r.scrolled = 1'b1;
      end
    end else if (cmd == ttx_pkg::CMD_CLEAR) begin
      for (int y = 0; y < nr; y++)
        for (int x = 0; x < nc; x++)
          screen[y*COLS_MAX + x] = '{bg: d[15:12], fg: d[11:8], ch: ttx_pkg::CH_SPACE};
      cur_x = 0;
      cur_y = 0;
      cur_fg = d[11:8];
      cur_bg = d[15:12];
      r.ev = ttx_pkg::EV_CLEAR;
    end else if (cmd == ttx_pkg::CMD_READ) begin
      c = '{bg: 4'd0, fg: 4'd0, ch: ttx_pkg::CH_SPACE};
      if (d[22:16] < nc && d[28:23] < nr) c = screen[d[28:23]*COLS_MAX + d[22:16]];
      r.ev = ttx_pkg::EV_READ;
      r.col = d[22:16];
      r.row = d[28:23];
      r.ch = c.ch;
      r.fg = c.fg;
      r.bg = c.bg;
    end
    r.ccol = cur_x[6:0];
    r.crow = cur_y[5:0];
    expected_results.push_back(r);
  endfunction

  // Input side: present queued commands and track accepted ones.
  always @(posedge clk) begin
    command_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        terminal_step(in_tuser, in_tdata);
        items_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (command_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = command_feed.pop_front();
          in_tuser <= it.cmd;
          in_tdata <= it.data;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Result side: random stalls, a long hold-off on request, field checks.
  always @(posedge clk) begin
    terminal_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_out++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (e.scrolled) scrolls_seen++;
          if (e.pw) palettes_seen++;
          if (e.ev == ttx_pkg::EV_WRITE) writes_seen++;
          check_field("event_res", e.ev, out_tuser);
          check_field("cell_col", e.col, out_tdata[6:0]);
          check_field("cell_row", e.row, out_tdata[12:7]);
          check_field("cell_char", e.ch, out_tdata[20:13]);
          check_field("cell_fg", e.fg, out_tdata[24:21]);
          check_field("cell_bg", e.bg, out_tdata[28:25]);
          check_field("scrolled", e.scrolled, out_tdata[29]);
          check_field("cursor_col", e.ccol, out_tdata[36:30]);
          check_field("cursor_row", e.crow, out_tdata[42:37]);
          check_field("palette_write", e.pw, out_tdata[43]);
          check_field("palette_index", e.pidx, out_tdata[47:44]);
          check_field("palette_rgb", e.rgb, out_tdata[71:48]);
        end
      end
      if (hold_asked != hold_done) begin
        hold_done <= hold_asked;
        hold_left <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  function automatic logic [31:0] noise();
    return {3'b000, 29'($urandom)};
  endfunction

  function automatic void push_cmd(input logic [1:0] cmd, input logic [31:0] d);
    command_feed.push_back('{cmd: cmd, data: d});
  endfunction

  function automatic void push_char(input logic [7:0] ch);
    logic [31:0] d;
    d = noise();
    d[7:0] = ch;
    push_cmd(ttx_pkg::CMD_PUT, d);
  endfunction

  function automatic void push_read(input int unsigned x, input int unsigned y);
    logic [31:0] d;
    d = noise();
    d[22:16] = 7'(x);
    d[28:23] = 6'(y);
    push_cmd(ttx_pkg::CMD_READ, d);
  endfunction

  function automatic void push_clear(input int unsigned fg, input int unsigned bg);
    logic [31:0] d;
    d = noise();
    d[11:8] = 4'(fg);
    d[15:12] = 4'(bg);
    push_cmd(ttx_pkg::CMD_CLEAR, d);
  endfunction

  function automatic void push_number(input int unsigned v);
    logic [7:0] digits [$];
    do begin
      digits.push_front(8'(ttx_pkg::CH_0 + v % 10));
      v = v / 10;
    end while (v > 0);
    foreach (digits[i]) push_char(digits[i]);
  endfunction

  function automatic void push_csi(input int unsigned vals [$], input logic [7:0] fin);
    push_char(ttx_pkg::CH_ESC);
    push_char(ttx_pkg::CH_LBRK);
    foreach (vals[i]) begin
      if (i > 0) push_char(ttx_pkg::CH_SEMI);
      push_number(vals[i]);
    end
    push_char(fin);
  endfunction

  function automatic int unsigned sgr_value();
    case ($urandom_range(0, 6))
      0: return $urandom_range(30, 37);
      1: return $urandom_range(40, 47);
      2: return $urandom_range(90, 97);
      3: return $urandom_range(100, 107);
      4: return $urandom_range(0, 1);
      5: return $urandom_range(0, 120);
      default: return $urandom_range(0, 70000);
    endcase
  endfunction

  // Mostly well-formed text and escape sequences, with some raw noise.
  function automatic void push_random(input int unsigned count, input bit allow_clear);
    int unsigned vals [$];
    int unsigned start, n;
    start = command_feed.size();
    while (command_feed.size() - start < count) begin
      n = $urandom_range(0, 99);
      vals = {};
      if (n < 45) begin
        repeat ($urandom_range(1, 8))
          push_char(8'(($urandom_range(0, 9) == 0) ? $urandom_range(128, 255)
                                                   : $urandom_range(32, 126)));
      end else if (n < 60) begin
        repeat ($urandom_range(1, 5)) vals.push_back(sgr_value());
        push_csi(vals, ttx_pkg::CH_M);
      end else if (n < 68) begin
        vals.push_back($urandom_range(0, 17));
        repeat ($urandom_range(2, 4)) vals.push_back($urandom_range(0, 300));
        push_csi(vals, ttx_pkg::CH_P);
      end else if (n < 78) begin
        case ($urandom_range(0, 3))
          0: push_char(ttx_pkg::CH_BS);
          1: push_char(ttx_pkg::CH_TAB);
          2: push_char(ttx_pkg::CH_LF);
          default: push_char(ttx_pkg::CH_CR);
        endcase
      end else if (n < 88) begin
        if ($urandom_range(0, 4) == 0) push_read($urandom_range(0, 127), $urandom_range(0, 63));
        else push_read($urandom_range(0, area_w() - 1), $urandom_range(0, area_h() - 1));
      end else if (n < 90) begin
        if (allow_clear) push_clear($urandom_range(0, 15), $urandom_range(0, 15));
      end else if (n < 97) begin
        push_char(8'($urandom_range(0, 255)));
      end else begin
        push_cmd(ttx_pkg::CMD_NOP, noise());
      end
    end
  endfunction

  // Sample at the falling edge so that every clocked update has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (command_feed.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Present one register write; valid is dropped by the caller after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == ttx_pkg::REG_COLUMNS) reg_cols = val;
    else if (idx == ttx_pkg::REG_ROWS) reg_rows = val[6:0];
    else if (idx == ttx_pkg::REG_DEF_FG) reg_dfg = val[3:0];
    else reg_dbg = val[3:0];
  endtask

  task automatic set_area(input int unsigned w, input int unsigned h,
                          input int unsigned fg, input int unsigned bg);
    wait_drained();
    write_reg(ttx_pkg::REG_COLUMNS, 8'(w));
    write_reg(ttx_pkg::REG_ROWS, 8'(h));
    write_reg(ttx_pkg::REG_DEF_FG, 8'(fg));
    write_reg(ttx_pkg::REG_DEF_BG, 8'(bg));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned vals [$];
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = ttx_pkg::CMD_NOP;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ttx_pkg::REG_COLUMNS;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asked = 0;
    hold_done = 0;
    hold_left = 0;
    errors = 0;
    items_in = 0;
    results_out = 0;
    writes_seen = 0;
    scrolls_seen = 0;
    palettes_seen = 0;
    dog = 0;
    reg_cols = 80;
    reg_rows = 25;
    reg_dfg = 7;
    reg_dbg = 0;
    foreach (screen[i]) screen[i] = ttx_pkg::CELL_RESET;
    cur_x = 0;
    cur_y = 0;
    reset_params();
    cur_fg = reg_dfg;
    cur_bg = reg_dbg;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset geometry: byte extremes, controls, parser corners.
    push_char(8'h00);
    push_char(8'hFF);
    push_char(ttx_pkg::CH_BS);
    push_char(ttx_pkg::CH_TAB);
    push_char(ttx_pkg::CH_CR);
    push_char(ttx_pkg::CH_BS);
    push_char(ttx_pkg::CH_LF);
    vals = {1, 31, 102, 47}; push_csi(vals, ttx_pkg::CH_M);
    push_char("A");
    vals = {95, 0};          push_csi(vals, ttx_pkg::CH_M);
    vals = {99999};          push_csi(vals, ttx_pkg::CH_M);
    vals = {1, 2, 3, 4, 107, 33}; push_csi(vals, ttx_pkg::CH_M);
    push_char("B");
    vals = {15, 511, 256, 255}; push_csi(vals, ttx_pkg::CH_P);
    vals = {16, 1, 2, 3};    push_csi(vals, ttx_pkg::CH_P);
    push_char(ttx_pkg::CH_M);
    vals = {3, 1, 2};        push_csi(vals, ttx_pkg::CH_P);
    push_char(ttx_pkg::CH_ESC);
    push_char(ttx_pkg::CH_ESC);
    push_char("x");
    push_char(8'd7);
    push_read(0, 0);
    push_read(127, 63);
    push_cmd(ttx_pkg::CMD_NOP, noise());
    push_clear(15, 0);
    push_read(79, 24);
    push_random(180, 1'b1);

    // Small area, sender mostly idle.
    set_area(8, 4, 15, 15);
    send_idle_pct = 69;
    recv_stall_pct = 0;
    push_char(ttx_pkg::CH_TAB);
    push_char(ttx_pkg::CH_TAB);
    push_random(380, 1'b1);

    // Zero registers act as a single cell; receiver mostly stalled.
    set_area(0, 0, 0, 0);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    push_random(150, 1'b1);

    // Largest area with oversized register values; both sides idle lightly.
    set_area(255, 127, 3, 12);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    repeat (3) push_char(ttx_pkg::CH_LF);
    push_read(127, 63);
    push_random(70, 1'b0);

    // Shrink the area with the cursor outside it, then hold off the receiver.
    set_area(16, 6, 9, 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_char("Z");
    push_char(ttx_pkg::CH_TAB);
    hold_asked++;
    push_random(400, 1'b1);

    // Medium area, both sides idling.
    set_area(128, 10, 12, 5);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    push_random(300, 1'b1);

    wait_drained();
    $display("Ran %0d commands over six screen geometries: %0d cell writes, %0d scrolls,",
             items_in, writes_seen, scrolls_seen);
    $display("%0d palette writes, %0d results checked, %0d mismatches.",
             palettes_seen, results_out, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
